// ===== sv/sms_pkg.sv =====
// Package for the sorted multiset store.
// Holds op codes and the input and result word structs; no dependencies.
package sms_pkg;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_REMOVE     = 3'd1;
    localparam logic [2:0] OP_REMOVE_MIN = 3'd2;
    localparam logic [2:0] OP_REMOVE_MAX = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic [4:0]         entry_count;
        logic               is_empty;
    } out_word_t;

    // Command from controller to datapath.
    typedef struct packed {
        logic               exec;
        logic [2:0]         op;
        logic signed [31:0] value;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic               ok;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic [4:0]         entry_count;
        logic               is_empty;
    } status_t;

endpackage

// ===== sv/sms_datapath.sv =====
// Datapath of the sorted multiset store: a row of sorted cells that shift
// in parallel on insert and remove.  Depends on sms_pkg.
module sms_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sms_pkg::cmd_t    cmd,
    output sms_pkg::status_t status
);
    import sms_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] cell_reg  [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic [CW-1:0]      count_reg, count_next;
    logic               ok_reg, ok_next;

    logic [CAPACITY-1:0] live, ge, eq, first_eq, before_eq;
    logic                found, full;

    // Per-cell compares against the operand
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live[i] = (CW'(i) < count_reg);
            ge[i]   = live[i] && (cmd.value <= cell_reg[i]);
            eq[i]   = live[i] && (cmd.value == cell_reg[i]);
        end
        before_eq[0] = 1'b0;
        for (int i = 1; i < CAPACITY; i++)
            before_eq[i] = before_eq[i-1] | eq[i-1];
        first_eq = eq & ~before_eq;
        found    = |eq;
        full     = (count_reg == CW'(CAPACITY));
    end

    // Next state of the cells
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_next[i] = cell_reg[i];
        count_next = count_reg;
        ok_next    = ok_reg;
        if (cmd.exec)
        begin
            ok_next = 1'b0;
            case (cmd.op)
                OP_INSERT:
                    if (!full)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg + CW'(1);
                        // first cell takes the value when it is ge or empty
                        if (ge[0] || !live[0])
                            cell_next[0] = cmd.value;
                        // cells at or beyond insertion point move up; the
                        // value lands where the previous cell is smaller
                        for (int i = 1; i < CAPACITY; i++)
                        begin
                            if (ge[i-1])
                                cell_next[i] = cell_reg[i-1];
                            else if (live[i-1] && (ge[i] || !live[i]))
                                cell_next[i] = cmd.value;
                        end
                    end
                OP_REMOVE:
                    if (found)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg - CW'(1);
                        for (int i = 0; i < CAPACITY - 1; i++)
                            if (before_eq[i] || first_eq[i])
                                cell_next[i] = cell_reg[i+1];
                    end
                OP_REMOVE_MIN:
                    if (count_reg != '0)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg - CW'(1);
                        for (int i = 0; i < CAPACITY - 1; i++)
                            cell_next[i] = cell_reg[i+1];
                    end
                OP_REMOVE_MAX:
                    if (count_reg != '0)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                OP_QUERY:
                    ok_next = found;
                default:
                    ok_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_reg[i] <= cell_next[i];
    end

    // Status taken from the stored row
    always_comb
    begin
        status.ok          = ok_reg;
        status.is_empty    = (count_reg == '0);
        status.entry_count = 5'(count_reg);
        status.smallest    = status.is_empty ? 32'sd0 : cell_reg[0];
        status.largest     = 32'sd0;
        for (int i = 0; i < CAPACITY; i++)
            if (CW'(i + 1) == count_reg)
                status.largest = cell_reg[i];
    end

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CW'(CAPACITY);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("count overflow");

    property p_full_reject;
        @(posedge clk) disable iff (!rst_n)
            (cmd.exec && cmd.op == OP_INSERT && full) |=> !ok_reg && $stable(count_reg);
    endproperty
    a_full_reject: assert property (p_full_reject) else $error("insert into full store");

    property p_query_stable;
        @(posedge clk) disable iff (!rst_n)
            (cmd.exec && cmd.op == OP_QUERY) |=> $stable(count_reg);
    endproperty
    a_query_stable: assert property (p_query_stable) else $error("query changed count");

endmodule

// ===== sv/sms_ctrl.sv =====
// Controller of the sorted multiset store: handshake and result slot.
// Depends on sms_pkg.
module sms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sms_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output sms_pkg::cmd_t     cmd
);
    import sms_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Accept whenever the result slot is free or being drained
    assign in_ready  = (state_reg == ST_IDLE) || out_ready;
    assign out_valid = (state_reg == ST_HOLD);
    assign cmd.exec  = in_valid && in_ready;
    assign cmd.op    = in_word.op;
    assign cmd.value = in_word.value;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd.exec) state_next = ST_HOLD;
            ST_HOLD: if (out_ready && !cmd.exec) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    property p_hold_stall;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && !out_ready) |=> out_valid;
    endproperty
    a_hold_stall: assert property (p_hold_stall) else $error("result dropped");

    property p_no_accept_blocked;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && !out_ready) |-> !cmd.exec;
    endproperty
    a_no_accept_blocked: assert property (p_no_accept_blocked) else $error("overwrite");

    property p_exec_result;
        @(posedge clk) disable iff (!rst_n) cmd.exec |=> out_valid;
    endproperty
    a_exec_result: assert property (p_exec_result) else $error("missing result");

endmodule

// ===== sv/sorted_multiset_store_unit.sv =====
// Sorted multiset store: ascending row of CAPACITY shifting cells.
// Result valid in the cycle after acceptance; one word per cycle while
// out_ready is high; every cell compares and shifts in parallel.
// Reset: asynchronous active-low rst_n empties the store; cell contents
// are not cleared and never read beyond the count.
module sorted_multiset_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sms_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output sms_pkg::out_word_t out_word
);
    import sms_pkg::*;

    cmd_t    cmd;
    status_t status;

    sms_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .in_word,
        .out_valid, .out_ready, .cmd
    );

    sms_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk, .rst_n, .cmd, .status
    );

    assign out_word.ok          = status.ok;
    assign out_word.smallest    = status.smallest;
    assign out_word.largest     = status.largest;
    assign out_word.entry_count = status.entry_count;
    assign out_word.is_empty    = status.is_empty;

endmodule

// ===== bench/sorted_multiset_store_unit_tb.sv =====
// Testbench for the sorted multiset store: directed and random op words,
// checked against an in-bench sorted array model. Depends on sms_pkg and the unit.
module sorted_multiset_store_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sms_pkg::*;

    localparam int CAP = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_word;
    logic out_valid;
    logic out_ready;
    out_word_t out_word;

    sorted_multiset_store_unit #(.CAPACITY(CAP)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    // Model state
    logic signed [31:0] model_cells[CAP];
    int model_count;

    in_word_t  pending_words[$];
    out_word_t expected_results[$];
    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_sender;
    bit stim_done;
    int quiet_cycles;
    bit timed_out;

    // Predict the result of one accepted word and update the model
    function automatic out_word_t predict_store(in_word_t w);
        out_word_t r;
        int pos;
        r.ok = 1'b0;
        case (w.op)
            OP_INSERT:
                if (model_count < CAP)
                begin
                    pos = 0;
                    while (pos < model_count && w.value > model_cells[pos]) pos++;
                    for (int i = model_count; i > pos; i--) model_cells[i] = model_cells[i-1];
                    model_cells[pos] = w.value;
                    model_count++;
                    r.ok = 1'b1;
                end
            OP_REMOVE:
            begin
                pos = 0;
                while (pos < model_count && model_cells[pos] != w.value) pos++;
                if (pos < model_count)
                begin
                    for (int i = pos; i + 1 < model_count; i++) model_cells[i] = model_cells[i+1];
                    model_count--;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE_MIN:
                if (model_count > 0)
                begin
                    for (int i = 0; i + 1 < model_count; i++) model_cells[i] = model_cells[i+1];
                    model_count--;
                    r.ok = 1'b1;
                end
            OP_REMOVE_MAX:
                if (model_count > 0)
                begin
                    model_count--;
                    r.ok = 1'b1;
                end
            OP_QUERY:
                for (int i = 0; i < model_count; i++)
                    if (model_cells[i] == w.value) r.ok = 1'b1;
            default: ;
        endcase
        r.entry_count = model_count[4:0];
        r.is_empty = (model_count == 0);
        r.smallest = (model_count > 0) ? model_cells[0] : 32'sd0;
        r.largest  = (model_count > 0) ? model_cells[model_count-1] : 32'sd0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Driver: present queued words, hold until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on input accept, check on output accept, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_store(in_word));
            if (out_valid && out_ready)
            begin
                out_word_t want;
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result word at %0t", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_word.ok !== want.ok)
                        report_mismatch("ok", 32'(out_word.ok), 32'(want.ok));
                    if (out_word.smallest !== want.smallest)
                        report_mismatch("smallest", out_word.smallest, want.smallest);
                    if (out_word.largest !== want.largest)
                        report_mismatch("largest", out_word.largest, want.largest);
                    if (out_word.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(out_word.entry_count),
                                        32'(want.entry_count));
                    if (out_word.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(out_word.is_empty),
                                        32'(want.is_empty));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [31:0] pick_value(int nearby);
        int k;
        k = $urandom_range(9);
        if (k < 6) return $signed(nearby + int'($urandom_range(6)) - 3);
        if (k == 6) return 32'sh7fffffff - $urandom_range(2);
        if (k == 7) return 32'sh80000000 + $urandom_range(2);
        return $signed($urandom());
    endfunction

    // Random burst that swings the fill level between empty and full
    task automatic queue_random(int n);
        in_word_t w;
        int bias;
        int k;
        bias = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0) bias = $urandom_range(2);
            k = $urandom_range(99);
            if (k < 2) w.op = 3'($urandom_range(7, 5));
            else if (k < 2 + (bias == 0 ? 55 : bias == 1 ? 30 : 15)) w.op = OP_INSERT;
            else w.op = 3'($urandom_range(4, 1));
            w.value = pick_value(0);
            pending_words.push_back(w);
        end
    endtask

    task automatic wait_drain();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_word(logic [2:0] op, logic signed [31:0] v);
        in_word_t w;
        w.op = op;
        w.value = v;
        pending_words.push_back(w);
    endtask

    // Stimulus
    initial
    begin
        hold_sender = 1'b0;
        stim_done = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 86;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty removes, extremes, duplicates, fill past capacity
        push_word(OP_REMOVE_MIN, 0);
        push_word(OP_REMOVE_MAX, 0);
        push_word(OP_REMOVE, 5);
        push_word(OP_QUERY, 0);
        push_word(OP_INSERT, 32'sh7fffffff);
        push_word(OP_INSERT, 32'sh80000000);
        push_word(OP_INSERT, 7);
        push_word(OP_INSERT, 7);
        push_word(OP_QUERY, 7);
        push_word(OP_REMOVE, 7);
        push_word(3'd5, 1);
        push_word(3'd7, -1);
        for (int i = 0; i < 14; i++) push_word(OP_INSERT, -i);
        push_word(OP_REMOVE, 1234);
        push_word(OP_REMOVE_MAX, 0);
        push_word(OP_REMOVE_MIN, 0);
        push_word(3'd6, 32'shffffffff);
        queue_random(700);
        wait_drain();

        // Sender pauses until every result is in
        hold_sender = 1'b1;
        queue_random(3);
        while (expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;

        send_idle_pct = 86;
        recv_idle_pct = 34;
        queue_random(650);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(650);
        wait_drain();
        stim_done = 1'b1;
    end

    // End of run
    initial
    begin
        timed_out = 1'b0;
        wait (rst_n === 1'b1);
        while (!stim_done && !timed_out)
        begin
            @(posedge clk);
            if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
        if (timed_out)
            $display("RESULT: ERROR");
        else if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/sms_pkg.sv
sv/sms_datapath.sv
sv/sms_ctrl.sv
sv/sorted_multiset_store_unit.sv
bench/sorted_multiset_store_unit_tb.sv
